/* rtl/ctt_pkg.sv */
// Shared types and codes for the config text tokenizer.
`default_nettype none
package ctt_pkg;

    // Lexer modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_WORD    = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_ESCAPE  = 3'd4;
    localparam logic [2:0] MODE_HEX1    = 3'd5;
    localparam logic [2:0] MODE_HEX2    = 3'd6;
    localparam logic [2:0] MODE_ERROR   = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_HEX    = 2'd1;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd2;

    localparam logic [7:0] COMMENT_CHAR_RESET = 8'h23;
    localparam logic [15:0] LINE_RESET = 16'd1;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified byte
    typedef struct packed {
        logic       end_of_text;
        logic [7:0] text_byte;
        logic       is_newline;
        logic       is_comment;
        logic       is_blank;
        logic       is_quote;
        logic       is_backslash;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       esc_hex;
        logic [7:0] esc_val;
    } t_item;

endpackage
`default_nettype wire

/* rtl/ctt_if.sv */
// Request channel interfaces for the tokenizer input and output.
`default_nettype none
interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        in_quoted;
    logic [7:0]  char_value;
    logic [1:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;

    modport source (output valid, output kind, output in_quoted, output char_value,
                    output error_code, output line_number, output column_number,
                    input ready);
    modport sink   (input valid, input kind, input in_quoted, input char_value,
                    input error_code, input line_number, input column_number,
                    output ready);
endinterface
`default_nettype wire

/* rtl/ctt_front.sv */
// Front end: accepts input requests and classifies each byte.
`default_nettype none
module ctt_front (
    input  wire logic         i_queue_full,
    input  wire logic [7:0]   i_comment_char,
    ctt_in_if.sink            i_in,
    output ctt_pkg::t_item    o_item,
    output logic              o_push
);

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        // {valid, value}
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    logic [7:0] c;
    logic [4:0] hd;

    assign c  = i_in.text_byte;
    assign hd = hex_digit(c);

    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full;

    always_comb begin
        o_item              = '0;
        o_item.end_of_text  = i_in.end_of_text;
        o_item.text_byte    = c;
        o_item.is_newline   = (c == 8'h0A);
        o_item.is_comment   = (c == i_comment_char);
        o_item.is_blank     = (c >= 8'h09 && c <= 8'h0D) || (c == 8'h20);
        o_item.is_quote     = (c == 8'h22);
        o_item.is_backslash = (c == 8'h5C);
        o_item.hex_ok       = hd[4];
        o_item.hex_val      = hd[3:0];
        o_item.esc_hex      = (c == 8'h78) || (c == 8'h58);
        unique case (c)
            8'h6E:   o_item.esc_val = 8'h0A; // n
            8'h72:   o_item.esc_val = 8'h0D; // r
            8'h62:   o_item.esc_val = 8'h08; // b
            8'h65:   o_item.esc_val = 8'h1B; // e
            8'h61:   o_item.esc_val = 8'h07; // a
            8'h74:   o_item.esc_val = 8'h09; // t
            8'h76:   o_item.esc_val = 8'h0B; // v
            default: o_item.esc_val = c;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ctt_queue.sv */
// Short FIFO of classified bytes between front and back.
`default_nettype none
module ctt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ctt_pkg::t_item i_item,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output ctt_pkg::t_item     o_item
);

    ctt_pkg::t_item r_mem [ctt_pkg::QUEUE_DEPTH];
    logic [ctt_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [ctt_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [ctt_pkg::QUEUE_CW-1:0] r_count, n_count;
    logic do_pop;

    assign o_full  = (r_count == ctt_pkg::QUEUE_CW'(ctt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [ctt_pkg::QUEUE_AW-1:0] ptr_inc(
        input logic [ctt_pkg::QUEUE_AW-1:0] p);
        logic [ctt_pkg::QUEUE_AW-1:0] r;
        if (p == ctt_pkg::QUEUE_AW'(ctt_pkg::QUEUE_DEPTH - 1)) r = '0;
        else r = p + 1'b1;
        return r;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !do_pop) n_count = r_count + 1'b1;
        else if (!i_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

/* rtl/ctt_back.sv */
// Back end: lexer state machine, position counters and output register.
`default_nettype none
module ctt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire ctt_pkg::t_item i_item,
    output logic                o_pop,
    ctt_out_if.source           o_out
);

    logic [2:0]  r_mode, n_mode;
    logic [3:0]  r_hex_hi, n_hex_hi;
    logic [15:0] r_line, n_line;
    logic [15:0] r_col, n_col;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic        r_quoted;
    logic [7:0]  r_char;
    logic [1:0]  r_code;
    logic [15:0] r_out_line;
    logic [15:0] r_out_col;

    logic        emit;
    logic [1:0]  e_kind;
    logic        e_quoted;
    logic [7:0]  e_char;
    logic [1:0]  e_code;
    logic [15:0] e_line;
    logic [15:0] e_col;

    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_mode   = r_mode;
        n_hex_hi = r_hex_hi;
        n_line   = r_line;
        n_col    = r_col;
        emit     = 1'b0;
        e_kind   = ctt_pkg::KIND_BYTE;
        e_quoted = 1'b0;
        e_char   = 8'd0;
        e_code   = ctt_pkg::ERR_NONE;
        e_line   = r_line;
        e_col    = r_col;

        if (i_item.end_of_text) begin
            unique case (r_mode)
                ctt_pkg::MODE_WORD: begin
                    emit   = 1'b1;
                    e_kind = ctt_pkg::KIND_END;
                end
                ctt_pkg::MODE_STRING, ctt_pkg::MODE_ESCAPE: begin
                    emit     = 1'b1;
                    e_kind   = ctt_pkg::KIND_ERROR;
                    e_quoted = 1'b1;
                    e_code   = ctt_pkg::ERR_UNTERM_STR;
                end
                ctt_pkg::MODE_HEX1, ctt_pkg::MODE_HEX2: begin
                    emit     = 1'b1;
                    e_kind   = ctt_pkg::KIND_ERROR;
                    e_quoted = 1'b1;
                    e_code   = ctt_pkg::ERR_BAD_HEX;
                end
                default: begin
                end
            endcase
            n_mode   = ctt_pkg::MODE_BETWEEN;
            n_hex_hi = 4'd0;
            n_line   = ctt_pkg::LINE_RESET;
            n_col    = 16'd0;
        end else begin
            // position first; results report the updated position
            if (i_item.is_newline) begin
                if (r_line != ctt_pkg::POS_MAX) n_line = r_line + 16'd1;
                n_col = 16'd0;
            end else if (r_col != ctt_pkg::POS_MAX) begin
                n_col = r_col + 16'd1;
            end
            e_line = n_line;
            e_col  = n_col;

            unique case (r_mode)
                ctt_pkg::MODE_BETWEEN, ctt_pkg::MODE_WORD: begin
                    if (i_item.is_comment || i_item.is_blank) begin
                        if (r_mode == ctt_pkg::MODE_WORD) begin
                            emit   = 1'b1;
                            e_kind = ctt_pkg::KIND_END;
                        end
                        n_mode = i_item.is_comment ? ctt_pkg::MODE_COMMENT
                                                   : ctt_pkg::MODE_BETWEEN;
                    end else if (r_mode == ctt_pkg::MODE_BETWEEN && i_item.is_quote) begin
                        n_mode = ctt_pkg::MODE_STRING;
                    end else begin
                        emit   = 1'b1;
                        e_char = i_item.text_byte;
                        n_mode = ctt_pkg::MODE_WORD;
                    end
                end
                ctt_pkg::MODE_COMMENT: begin
                    if (i_item.is_newline) n_mode = ctt_pkg::MODE_BETWEEN;
                end
                ctt_pkg::MODE_STRING: begin
                    if (i_item.is_quote) begin
                        emit     = 1'b1;
                        e_kind   = ctt_pkg::KIND_END;
                        e_quoted = 1'b1;
                        n_mode   = ctt_pkg::MODE_BETWEEN;
                    end else if (i_item.is_backslash) begin
                        n_mode = ctt_pkg::MODE_ESCAPE;
                    end else begin
                        emit     = 1'b1;
                        e_quoted = 1'b1;
                        e_char   = i_item.text_byte;
                    end
                end
                ctt_pkg::MODE_ESCAPE: begin
                    if (i_item.esc_hex) begin
                        n_mode = ctt_pkg::MODE_HEX1;
                    end else begin
                        emit     = 1'b1;
                        e_quoted = 1'b1;
                        e_char   = i_item.esc_val;
                        n_mode   = ctt_pkg::MODE_STRING;
                    end
                end
                ctt_pkg::MODE_HEX1: begin
                    if (!i_item.hex_ok) begin
                        emit     = 1'b1;
                        e_kind   = ctt_pkg::KIND_ERROR;
                        e_quoted = 1'b1;
                        e_code   = ctt_pkg::ERR_BAD_HEX;
                        n_mode   = ctt_pkg::MODE_ERROR;
                    end else begin
                        n_hex_hi = i_item.hex_val;
                        n_mode   = ctt_pkg::MODE_HEX2;
                    end
                end
                ctt_pkg::MODE_HEX2: begin
                    emit     = 1'b1;
                    e_quoted = 1'b1;
                    if (!i_item.hex_ok) begin
                        e_kind = ctt_pkg::KIND_ERROR;
                        e_code = ctt_pkg::ERR_BAD_HEX;
                        n_mode = ctt_pkg::MODE_ERROR;
                    end else begin
                        e_char = {r_hex_hi, i_item.hex_val};
                        n_mode = ctt_pkg::MODE_STRING;
                    end
                end
                default: begin
                    // sticky error: swallow bytes until end of text
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ctt_pkg::MODE_BETWEEN;
            r_hex_hi    <= 4'd0;
            r_line      <= ctt_pkg::LINE_RESET;
            r_col       <= 16'd0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_mode      <= n_mode;
            r_hex_hi    <= n_hex_hi;
            r_line      <= n_line;
            r_col       <= n_col;
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind     <= e_kind;
            r_quoted   <= e_quoted;
            r_char     <= e_char;
            r_code     <= e_code;
            r_out_line <= e_line;
            r_out_col  <= e_col;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.in_quoted     = r_quoted;
    assign o_out.char_value    = r_char;
    assign o_out.error_code    = r_code;
    assign o_out.line_number   = r_out_line;
    assign o_out.column_number = r_out_col;

endmodule
`default_nettype wire

/* rtl/config_text_tokenizer_core.sv */
// Top level of the config text tokenizer.
`default_nettype none
// Splits a byte stream into tokens: whitespace-separated words, quoted
// strings with backslash escapes (n r b e a t v, x/X with two hex digits),
// and comments from the comment character to end of line. Each token byte
// comes out as one result, followed by an end-of-token result; a bad hex
// digit or end of text inside a string gives an error result, and the
// block stays silent after a bad hex digit until end of text. Every result
// carries the saturating line and column of the last byte read.
// Throughput is one byte per clock while the output is not stalled: the
// back-end state machine updates its mode and position counters as it pops
// each byte. A request is written into a two-entry queue, and its result
// (if any) is then held in the output register until it is taken.
// The user writes the comment character through i_cfg_we / i_cfg_data
// while the block is idle; the block does not enforce this. It resets to '#'.
module config_text_tokenizer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    ctt_in_if.sink          i_in,
    ctt_out_if.source       o_out
);

    logic [7:0]     r_comment_char;
    ctt_pkg::t_item front_item;
    ctt_pkg::t_item q_item;
    logic           front_push;
    logic           q_full;
    logic           q_valid;
    logic           back_pop;

    // Comment character register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comment_char <= ctt_pkg::COMMENT_CHAR_RESET;
        end else if (i_cfg_we) begin
            r_comment_char <= i_cfg_data;
        end
    end

    // Front: classify incoming bytes, push into the queue
    ctt_front u_front (
        .i_queue_full   (q_full),
        .i_comment_char (r_comment_char),
        .i_in           (i_in),
        .o_item         (front_item),
        .o_push         (front_push)
    );

    // Decoupling queue: lets input and output stall independently
    ctt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: lexer state machine and registered result
    ctt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (back_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

/* test/tb_config_text_tokenizer_core.sv */
// Self-checking testbench for the config text tokenizer core.
`default_nettype none
module tb_config_text_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ctt_pkg::*;

    // Byte codes the lexer reacts to
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] ESC_CODE  = 8'h1B;
    localparam logic [4:0] NO_DIGIT  = 5'd16;
    localparam logic [55:0] ESC_LETTERS = "nrbeatv";

    // Run shape
    localparam int SEGMENT_ITEMS  = 170;    // requests per random segment (six segments)
    localparam int DRAIN_CYCLES   = 8;      // queue + output register, with margin
    localparam int HOLD_AT        = 40;     // result count that starts the long hold-off
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  kind;
        logic        in_quoted;
        logic [7:0]  char_value;
        logic [1:0]  error_code;
        logic [15:0] line_number;
        logic [15:0] column_number;
    } tok_result_t;

    typedef struct {
        logic [7:0]  b;
        logic        eot;
        bit          typed;
        bit          has;
        tok_result_t res;
    } dir_row_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [7:0] cfg_data = 8'h00;

    ctt_in_if  in_ch ();
    ctt_out_if out_ch ();

    config_text_tokenizer_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state, mirrors the block's registers
    logic [7:0]  comment_byte = COMMENT_CHAR_RESET;
    logic [2:0]  lex_mode     = MODE_BETWEEN;
    logic [3:0]  hex_hi       = 4'd0;
    logic [15:0] line_cnt     = LINE_RESET;
    logic [15:0] col_cnt      = 16'd0;

    tok_result_t predicted_tokens[$];
    dir_row_t    dir_rows[$];

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int sender_gap_pct = 0;
    int stall_pct      = 0;

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return 5'(b - "0");
        if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
        if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
        return NO_DIGIT;
    endfunction

    // A result carries the position after the current byte, or the one before end of text
    function automatic tok_result_t make_token(input logic [1:0] kind, input logic quoted,
                                               input logic [7:0] value, input logic [1:0] code);
        tok_result_t r;
        r.kind          = kind;
        r.in_quoted     = quoted;
        r.char_value    = value;
        r.error_code    = code;
        r.line_number   = line_cnt;
        r.column_number = col_cnt;
        return r;
    endfunction

    // One byte through the lexer: updates state, returns the token output if any
    task automatic tokenize_step(input logic [7:0] b, input logic eot,
                                 output bit produced, output tok_result_t res);
        logic [4:0] d;
        logic [7:0] v;
        produced = 1'b0;
        res      = '0;
        v        = 8'h00;
        if (eot) begin
            // position reported is the one before end of text
            case (lex_mode)
                MODE_WORD: begin
                    produced = 1'b1;
                    res = make_token(KIND_END, 1'b0, 8'h00, ERR_NONE);
                end
                MODE_STRING, MODE_ESCAPE: begin
                    produced = 1'b1;
                    res = make_token(KIND_ERROR, 1'b1, 8'h00, ERR_UNTERM_STR);
                end
                MODE_HEX1, MODE_HEX2: begin
                    produced = 1'b1;
                    res = make_token(KIND_ERROR, 1'b1, 8'h00, ERR_BAD_HEX);
                end
                default: ;
            endcase
            lex_mode = MODE_BETWEEN;
            hex_hi   = 4'd0;
            line_cnt = LINE_RESET;
            col_cnt  = 16'd0;
        end else begin
            if (b == CH_NL) begin
                if (line_cnt != POS_MAX) line_cnt++;
                col_cnt = 16'd0;
            end else if (col_cnt != POS_MAX) begin
                col_cnt++;
            end
            case (lex_mode)
                MODE_BETWEEN, MODE_WORD: begin
                    // comment char wins over blanks and the quote
                    if (b == comment_byte || (b >= 8'd9 && b <= 8'd13) || b == CH_SPACE) begin
                        if (lex_mode == MODE_WORD) begin
                            produced = 1'b1;
                            res = make_token(KIND_END, 1'b0, 8'h00, ERR_NONE);
                        end
                        lex_mode = (b == comment_byte) ? MODE_COMMENT : MODE_BETWEEN;
                    end else if (lex_mode == MODE_BETWEEN && b == CH_QUOTE) begin
                        lex_mode = MODE_STRING;
                    end else begin
                        produced = 1'b1;
                        res = make_token(KIND_BYTE, 1'b0, b, ERR_NONE);
                        lex_mode = MODE_WORD;
                    end
                end
                MODE_COMMENT: begin
                    if (b == CH_NL) lex_mode = MODE_BETWEEN;
                end
                MODE_STRING: begin
                    if (b == CH_QUOTE) begin
                        produced = 1'b1;
                        res = make_token(KIND_END, 1'b1, 8'h00, ERR_NONE);
                        lex_mode = MODE_BETWEEN;
                    end else if (b == CH_BSLASH) begin
                        lex_mode = MODE_ESCAPE;
                    end else begin
                        produced = 1'b1;
                        res = make_token(KIND_BYTE, 1'b1, b, ERR_NONE);
                    end
                end
                MODE_ESCAPE: begin
                    lex_mode = MODE_STRING;
                    produced = 1'b1;
                    case (b)
                        "n": v = 8'h0A;
                        "r": v = 8'h0D;
                        "b": v = 8'h08;
                        "e": v = ESC_CODE;
                        "a": v = 8'h07;
                        "t": v = 8'h09;
                        "v": v = 8'h0B;
                        "x", "X": begin
                            lex_mode = MODE_HEX1;
                            produced = 1'b0;
                        end
                        default: v = b;
                    endcase
                    if (produced) res = make_token(KIND_BYTE, 1'b1, v, ERR_NONE);
                end
                MODE_HEX1, MODE_HEX2: begin
                    d = hex_nibble(b);
                    if (d == NO_DIGIT) begin
                        produced = 1'b1;
                        res = make_token(KIND_ERROR, 1'b1, 8'h00, ERR_BAD_HEX);
                        lex_mode = MODE_ERROR;
                    end else if (lex_mode == MODE_HEX1) begin
                        hex_hi   = d[3:0];
                        lex_mode = MODE_HEX2;
                    end else begin
                        produced = 1'b1;
                        res = make_token(KIND_BYTE, 1'b1, {hex_hi, d[3:0]}, ERR_NONE);
                        lex_mode = MODE_STRING;
                    end
                end
                default: ;  // error mode swallows bytes until end of text
            endcase
        end
    endtask

    // Offer one request; predict once it is taken. Typed rows override the predictor.
    task automatic push_request(input logic [7:0] b, input logic eot, input bit typed,
                                input bit typed_has, input tok_result_t typed_res);
        bit          has;
        tok_result_t res;
        while ($urandom_range(99) < sender_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= b;
        in_ch.end_of_text <= eot;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        items_sent++;
        tokenize_step(b, eot, has, res);
        if (typed) begin
            has = typed_has;
            res = typed_res;
        end
        if (has) predicted_tokens.push_back(res);
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_request(b, 1'b0, 1'b0, 1'b0, '0);
    endtask

    // End of text; the byte rides along with random content
    task automatic send_end();
        push_request(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, '0);
    endtask

    function automatic logic [7:0] random_blank();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? CH_SPACE : 8'(9 + r);
    endfunction

    function automatic logic [7:0] word_byte();
        if ($urandom_range(3) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(126, 33));
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'("0" + v);
        return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] bad_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (hex_nibble(b) != NO_DIGIT);
        return b;
    endfunction

    function automatic logic [7:0] hex_x();
        return $urandom_range(1) ? "x" : "X";
    endfunction

    // String content: plain bytes and every escape form
    task automatic send_string_body(input int pieces);
        int         k;
        logic [7:0] b;
        for (k = 0; k < pieces; k++) begin
            case ($urandom_range(9))
                5, 6: begin
                    send_byte(CH_BSLASH);
                    send_byte(ESC_LETTERS[8 * $urandom_range(6) +: 8]);
                end
                7: begin
                    send_byte(CH_BSLASH);
                    send_byte(hex_x());
                    send_byte(hex_char());
                    send_byte(hex_char());
                end
                8: begin
                    b = 8'($urandom_range(255));
                    if (b == "x" || b == "X") b = "y";
                    send_byte(CH_BSLASH);
                    send_byte(b);
                end
                9: begin
                    send_byte(CH_BSLASH);
                    send_byte($urandom_range(1) ? CH_QUOTE : CH_BSLASH);
                end
                default: begin
                    b = 8'($urandom_range(255));
                    if (b == CH_QUOTE || b == CH_BSLASH) b = "s";
                    send_byte(b);
                end
            endcase
        end
    endtask

    // Mostly well-formed tokens, some broken strings and plain noise
    task automatic send_chunk();
        int pick, n, k;
        bit bad;
        pick = $urandom_range(99);
        n    = 0;
        bad  = 1'b0;
        if (pick < 30) begin
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++) send_byte(word_byte());
            send_byte(random_blank());
        end else if (pick < 55) begin
            send_byte(CH_QUOTE);
            send_string_body($urandom_range(6));
            send_byte(CH_QUOTE);
            send_byte(random_blank());
        end else if (pick < 65) begin
            send_byte(comment_byte);
            n = $urandom_range(5);
            for (k = 0; k < n; k++) send_byte(word_byte());
            send_byte(CH_NL);
        end else if (pick < 72) begin
            n = $urandom_range(3, 1);
            for (k = 0; k < n; k++) send_byte(random_blank());
        end else if (pick < 82) begin
            // broken string: bad hex digit, or end of text mid-string/escape/hex
            send_byte(CH_QUOTE);
            send_string_body($urandom_range(3));
            case ($urandom_range(4))
                0: begin
                    send_byte(CH_BSLASH);
                    send_byte(hex_x());
                    send_byte(bad_hex());
                    bad = 1'b1;
                end
                1: begin
                    send_byte(CH_BSLASH);
                    send_byte(hex_x());
                    send_byte(hex_char());
                    send_byte(bad_hex());
                    bad = 1'b1;
                end
                2: send_byte(CH_BSLASH);
                3: begin
                    send_byte(CH_BSLASH);
                    send_byte(hex_x());
                    if ($urandom_range(1)) send_byte(hex_char());
                end
                default: ;
            endcase
            if (bad) n = $urandom_range(3);
            for (k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
            send_end();
        end else if (pick < 88) begin
            n = $urandom_range(4, 1);
            for (k = 0; k < n; k++) send_byte(word_byte());
            send_end();
        end else if (pick < 92) begin
            send_end();
        end else begin
            n = $urandom_range(3, 1);
            for (k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
        end
    endtask

    // Let everything in flight come out, including bytes that give no result
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (predicted_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_comment_char(input logic [7:0] c);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
        comment_byte = c;
    endtask

    task automatic add_pred(input logic [7:0] b, input logic eot);
        dir_row_t row;
        row.b     = b;
        row.eot   = eot;
        row.typed = 1'b0;
        row.has   = 1'b0;
        row.res   = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [7:0] b, input logic eot, input bit has,
                             input logic [1:0] kind, input logic q, input logic [7:0] val,
                             input logic [1:0] code, input logic [15:0] ln,
                             input logic [15:0] col);
        dir_row_t row;
        row.b     = b;
        row.eot   = eot;
        row.typed = 1'b1;
        row.has   = has;
        row.res   = '{kind: kind, in_quoted: q, char_value: val, error_code: code,
                      line_number: ln, column_number: col};
        dir_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: check each accepted result, random stalls plus one long hold-off
    initial begin : result_sink
        tok_result_t want;
        int          hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (predicted_tokens.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                             $time, out_ch.kind, out_ch.char_value);
                    errors++;
                end else begin
                    want = predicted_tokens.pop_front();
                    check_field("kind", 16'(want.kind), 16'(out_ch.kind));
                    check_field("in_quoted", 16'(want.in_quoted), 16'(out_ch.in_quoted));
                    check_field("char_value", 16'(want.char_value), 16'(out_ch.char_value));
                    check_field("error_code", 16'(want.error_code), 16'(out_ch.error_code));
                    check_field("line_number", want.line_number, out_ch.line_number);
                    check_field("column_number", want.column_number, out_ch.column_number);
                end
            end
            // hold ready low long enough for the queue to fill and back up the input
            if (!hold_done && results_seen == HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Ends the run if nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int seg, start;
        in_ch.valid       <= 1'b0;
        in_ch.text_byte   <= 8'h00;
        in_ch.end_of_text <= 1'b0;

        // Directed rows, comment char '#'. Typed rows: position easy to read off.
        add_typed("a",      1'b0, 1'b1, KIND_BYTE, 1'b0, "a",   ERR_NONE, 16'd1, 16'd1);
        add_typed(8'hFF,    1'b0, 1'b1, KIND_BYTE, 1'b0, 8'hFF, ERR_NONE, 16'd1, 16'd2);
        add_typed(CH_SPACE, 1'b0, 1'b1, KIND_END,  1'b0, 8'h00, ERR_NONE, 16'd1, 16'd3);
        add_typed(8'h00,    1'b0, 1'b1, KIND_BYTE, 1'b0, 8'h00, ERR_NONE, 16'd1, 16'd4);
        add_pred(CH_QUOTE, 1'b0);   // quote inside a word is a plain byte
        add_pred("#", 1'b0);        // comment ends the word
        add_pred("z", 1'b0);
        add_pred(CH_NL, 1'b0);
        add_pred(CH_QUOTE, 1'b0);   // string opens, line 2
        add_pred(CH_BSLASH, 1'b0);
        add_pred("n", 1'b0);
        add_pred(CH_BSLASH, 1'b0);
        add_pred("x", 1'b0);
        add_pred("F", 1'b0);
        add_pred("0", 1'b0);
        add_pred(CH_BSLASH, 1'b0);
        add_pred("q", 1'b0);        // unknown escape stands for itself
        add_pred(CH_QUOTE, 1'b0);
        add_pred(CH_QUOTE, 1'b0);
        add_pred(CH_BSLASH, 1'b0);
        add_pred("X", 1'b0);
        add_typed("g",      1'b0, 1'b1, KIND_ERROR, 1'b1, 8'h00, ERR_BAD_HEX, 16'd2, 16'd14);
        add_typed("a",      1'b0, 1'b0, KIND_BYTE,  1'b0, 8'h00, ERR_NONE, 16'd0, 16'd0);
        add_typed(8'hFF,    1'b1, 1'b0, KIND_BYTE,  1'b0, 8'h00, ERR_NONE, 16'd0, 16'd0);
        add_typed(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE,  1'b0, 8'h00, ERR_NONE, 16'd0, 16'd0);
        add_typed(8'h00,    1'b1, 1'b1, KIND_ERROR, 1'b1, 8'h00, ERR_UNTERM_STR,
                  16'd1, 16'd1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        sender_gap_pct = 12;
        stall_pct      = 82;
        write_comment_char(COMMENT_CHAR_RESET);
        foreach (dir_rows[i])
            push_request(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].typed,
                         dir_rows[i].has, dir_rows[i].res);

        // Random segments; comment char set to extremes and to bytes that
        // collide with the quote, a blank and the backslash
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: write_comment_char(8'h00);
                1: write_comment_char(8'hFF);
                2: write_comment_char(CH_QUOTE);
                3: write_comment_char(CH_SPACE);
                4: write_comment_char(8'($urandom_range(255)));
                default: write_comment_char(CH_BSLASH);
            endcase
            case (seg / 2)
                0: begin
                    sender_gap_pct = 12;
                    stall_pct      = 82;
                end
                1: begin
                    sender_gap_pct = 82;
                    stall_pct      = 12;
                end
                default: begin
                    sender_gap_pct = 0;
                    stall_pct      = 0;
                end
            endcase
            start = items_sent;
            while (items_sent - start < SEGMENT_ITEMS) send_chunk();
        end

        wait_idle();
        if (errors == 0 && predicted_tokens.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire
